// ===== rtl/nafir_pkg.sv =====
package nafir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int STEP_W = 16;
   localparam int REG_W = 32;
   localparam int CSR_INDEX_W = 1;

   // Gain numerator is step_size * 2^44; quotient carries 30 fraction bits.
   localparam int STEP_SHIFT = 44;
   localparam int NUM_W = STEP_W + STEP_SHIFT;
   localparam int ALPHA_FRAC = 30;
   localparam int DIV_CNT_W = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGULARIZER = 1'b1;

   localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd66;
   localparam logic [REG_W-1:0] REGULARIZER_RESET = 32'd11;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] reference_sample;
      logic signed [SAMPLE_W-1:0] desired_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filter_output;
      logic signed [SAMPLE_W-1:0] error_output;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SUM   = 6'b000100,
      S_DIV   = 6'b001000,
      S_UPD   = 6'b010000,
      S_POST  = 6'b100000
   } state_type;

endpackage

// ===== rtl/nafir_store.sv =====
module nafir_store #(
   parameter int TAPS = 16,
   parameter int TW = 4
) (
   input  logic                           clock,
   input  logic                           dl_we,
   input  logic [TW-1:0]                  dl_waddr,
   input  logic [nafir_pkg::SAMPLE_W-1:0] dl_wdata,
   input  logic [TW-1:0]                  dl_raddr,
   output logic [nafir_pkg::SAMPLE_W-1:0] dl_rdata,
   input  logic                           wt_we,
   input  logic [TW-1:0]                  wt_waddr,
   input  logic [nafir_pkg::WEIGHT_W-1:0] wt_wdata,
   input  logic [TW-1:0]                  wt_raddr,
   output logic [nafir_pkg::WEIGHT_W-1:0] wt_rdata
);
   import nafir_pkg::*;

   logic [SAMPLE_W-1:0] dl_mem [TAPS];
   logic [WEIGHT_W-1:0] wt_mem [TAPS];

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      dl_rdata <= dl_mem[dl_raddr];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_waddr] <= wt_wdata;
      end
      wt_rdata <= wt_mem[wt_raddr];
   end

endmodule

// ===== rtl/nafir_div.sv =====
module nafir_div #(
   parameter int DEN_W = 36
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [nafir_pkg::STEP_W-1:0] step,
   input  logic [DEN_W-1:0]             den,
   output nafir_pkg::div_status_type    status,
   output logic [nafir_pkg::NUM_W-1:0]  quot
);
   import nafir_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [NUM_W-1:0]     q_ff, q_in;
   logic                 zero_ff, zero_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;

   // One quotient bit a cycle, restoring form.
   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign diff = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = DIV_CNT_W'(NUM_W);
         rem_in = '0;
         den_in = den;
         q_in = {step, STEP_SHIFT'(0)};
         zero_in = (den == '0);
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
      zero_ff <= zero_in;
   end

   // A zero divisor only happens with an all-zero line: drop the gain.
   assign quot = zero_ff ? '0 : q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTH
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without run");
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0) else $error("divider count left over");
`endif

endmodule

// ===== rtl/nlms_adaptive_fir.sv =====
// Normalized LMS adaptive FIR filter. Each request word carries a reference
// sample x and a desired sample d (Q1.15); each produces one response word
// with the filter output y (computed with the weights before adaptation) and
// the error d - y, both saturated to 16 bits. The delay line and the Q2.30
// weights live in two single-port-read memories of TAPS entries. Each word
// is handled by a pass that reads line and weights to form y and the input
// energy, a bit-serial divide for the normalized gain, and a second pass
// that reads, adapts and writes back every weight; the single read port of
// each memory makes each pass visit the taps one at a time. After reset the
// block zeroes both memories and holds req_stall high meanwhile. step_size
// and regularizer must be written on the csr port only while no word is in
// flight; the block itself does not enforce this.
module nlms_adaptive_fir #(
   parameter int TAPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  nafir_pkg::req_word_type              req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output nafir_pkg::rsp_word_type              rsp_data,
   input  logic                                 csr_we,
   input  logic [nafir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nafir_pkg::REG_W-1:0]          csr_wdata
);
   import nafir_pkg::*;

   localparam int TW = $clog2(TAPS);
   localparam int PROD_W = WEIGHT_W + SAMPLE_W;
   localparam int ACC_W = PROD_W + TW;
   localparam int SQ_W = 2 * SAMPLE_W - 1;
   localparam int ENG_W = SQ_W + TW;
   localparam int DEN_W = ENG_W + 1;
   localparam int Y_W = ACC_W - ALPHA_FRAC;
   localparam int E_W = Y_W + 1;
   localparam int M_W = SQ_W;
   localparam int AH_W = NUM_W - ALPHA_FRAC;
   localparam int P_W = AH_W + M_W;
   localparam int NW_W = P_W + 2;
   localparam logic [TW-1:0] LAST = TW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd536870912);
   localparam logic signed [NW_W-1:0] W_MAX = NW_W'(64'sd2147483647);
   localparam logic signed [NW_W-1:0] W_MIN = -NW_W'(64'sd2147483648);

   state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff;
   logic [REG_W-1:0]  regz_ff;

   logic [TW-1:0] wi_ff, wi_in;
   logic [TW-1:0] k_ff, k_in;
   logic [TW-1:0] rd_ff, rd_in;
   logic          iss_ff, iss_in;
   logic          rv_ff, mv_ff, pv_ff;
   logic [TW-1:0] k1_ff, k2_ff, k3_ff;

   logic signed [SAMPLE_W-1:0] d_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [ENG_W-1:0]           eng_ff, eng_in;
   logic signed [SAMPLE_W-1:0] ys_ff, es_ff;

   logic [M_W-1:0]             m_ff;
   logic                       neg_ff, neg2_ff;
   logic signed [WEIGHT_W-1:0] w1_ff, w2_ff;
   logic [P_W-1:0]             phi_ff, plo_ff;
   logic [NUM_W-1:0]           alpha_ff;

   logic [SAMPLE_W-1:0] dl_rdata;
   logic [WEIGHT_W-1:0] wt_rdata;
   logic                dl_we, wt_we;
   logic [TW-1:0]       dl_waddr, wt_waddr;
   logic [SAMPLE_W-1:0] dl_wdata;
   logic [WEIGHT_W-1:0] wt_wdata;

   logic            div_start;
   div_status_type  div_st;
   logic [NUM_W-1:0] div_quot;
   logic [DEN_W-1:0] den;

   logic                 rsp_valid_ff;
   rsp_word_type         rsp_data_ff;

   logic req_take, rsp_load, pipe_idle, last_iss;

   logic signed [SAMPLE_W-1:0] s_rd;
   logic signed [WEIGHT_W-1:0] w_rd;
   logic signed [2*SAMPLE_W-1:0] sq_full;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [Y_W-1:0]   y_full;
   logic signed [E_W-1:0]   e_full;
   logic signed [SAMPLE_W-1:0] ys_sat, es_sat;
   logic [SAMPLE_W-1:0] ea, xa;
   logic [P_W-1:0] mag;
   logic signed [NW_W-1:0] w_ext, mag_ext, nw;
   logic signed [WEIGHT_W-1:0] nw_sat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SIZE_RESET;
         regz_ff <= REGULARIZER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_ff <= csr_wdata[STEP_W-1:0];
            CSR_REGULARIZER: regz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_load = (state_ff == S_POST) && (!rsp_valid_ff || !rsp_stall);
   assign pipe_idle = !iss_ff && !rv_ff && !mv_ff && !pv_ff;
   assign last_iss = iss_ff && (k_ff == LAST);

   assign s_rd = dl_rdata;
   assign w_rd = wt_rdata;

   // Output rounding: round half up, then clamp.
   assign acc_rnd = acc_ff + RND;
   assign y_full = acc_rnd[ACC_W-1:ALPHA_FRAC];
   assign e_full = E_W'(d_ff) - E_W'(y_full);
   always_comb begin
      if (y_full > Y_W'(SAMPLE_MAX)) begin
         ys_sat = SAMPLE_MAX;
      end else if (y_full < Y_W'(SAMPLE_MIN)) begin
         ys_sat = SAMPLE_MIN;
      end else begin
         ys_sat = y_full[SAMPLE_W-1:0];
      end
      if (e_full > E_W'(SAMPLE_MAX)) begin
         es_sat = SAMPLE_MAX;
      end else if (e_full < E_W'(SAMPLE_MIN)) begin
         es_sat = SAMPLE_MIN;
      end else begin
         es_sat = e_full[SAMPLE_W-1:0];
      end
   end

   assign den = DEN_W'(regz_ff) + DEN_W'(eng_ff);
   assign div_start = (state_ff == S_SUM) && pipe_idle;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      wi_in = wi_ff;
      k_in = k_ff;
      rd_in = rd_ff;
      iss_in = iss_ff;
      if (iss_ff) begin
         k_in = k_ff + 1'b1;
         rd_in = (rd_ff == '0) ? LAST : rd_ff - 1'b1;
         if (last_iss) begin
            iss_in = 1'b0;
            k_in = '0;
         end
      end
      unique case (state_ff)
         S_CLEAR: begin
            if (k_ff == LAST) begin
               state_in = S_IDLE;
               k_in = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SUM;
               k_in = '0;
               rd_in = wi_ff;
               iss_in = 1'b1;
            end
         end
         S_SUM: begin
            if (pipe_idle) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               state_in = S_UPD;
               k_in = '0;
               rd_in = wi_ff;
               iss_in = 1'b1;
            end
         end
         S_UPD: begin
            if (pipe_idle) begin
               state_in = S_POST;
               wi_in = (wi_ff == LAST) ? '0 : wi_ff + 1'b1;
            end
         end
         S_POST: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         wi_ff <= '0;
         k_ff <= '0;
         rd_ff <= '0;
         iss_ff <= 1'b0;
         rv_ff <= 1'b0;
         mv_ff <= 1'b0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wi_ff <= wi_in;
         k_ff <= k_in;
         rd_ff <= rd_in;
         iss_ff <= iss_in;
         rv_ff <= iss_ff;
         mv_ff <= rv_ff;
         pv_ff <= mv_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sq_full = s_rd * s_rd;
   assign acc_in = mv_ff && (state_ff == S_SUM) ? acc_ff + ACC_W'(prod_ff) : acc_ff;
   assign eng_in = mv_ff && (state_ff == S_SUM) ? eng_ff + ENG_W'(sq_ff) : eng_ff;

   // Magnitudes for the update; negating the most negative code still
   // gives the right unsigned value.
   assign ea = es_ff[SAMPLE_W-1] ? SAMPLE_W'(-es_ff) : es_ff;
   assign xa = s_rd[SAMPLE_W-1] ? SAMPLE_W'(-s_rd) : s_rd;

   assign mag = phi_ff + P_W'(plo_ff[P_W-1:ALPHA_FRAC]);
   assign w_ext = NW_W'(w2_ff);
   assign mag_ext = $signed({2'b00, mag});
   assign nw = neg2_ff ? w_ext - mag_ext : w_ext + mag_ext;
   always_comb begin
      if (nw > W_MAX) begin
         nw_sat = W_MAX[WEIGHT_W-1:0];
      end else if (nw < W_MIN) begin
         nw_sat = W_MIN[WEIGHT_W-1:0];
      end else begin
         nw_sat = nw[WEIGHT_W-1:0];
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         d_ff <= req_data.desired_sample;
         acc_ff <= '0;
         eng_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         eng_ff <= eng_in;
      end
      k1_ff <= k_ff;
      k2_ff <= k1_ff;
      k3_ff <= k2_ff;
      prod_ff <= PROD_W'(w_rd) * PROD_W'(s_rd);
      sq_ff <= sq_full[SQ_W-1:0];
      if (div_start) begin
         ys_ff <= ys_sat;
         es_ff <= es_sat;
      end
      if (div_st.done) begin
         alpha_ff <= div_quot;
      end
      m_ff <= M_W'(32'(ea) * 32'(xa));
      neg_ff <= es_ff[SAMPLE_W-1] ^ s_rd[SAMPLE_W-1];
      w1_ff <= w_rd;
      phi_ff <= P_W'(alpha_ff[NUM_W-1:ALPHA_FRAC]) * P_W'(m_ff);
      plo_ff <= P_W'(alpha_ff[ALPHA_FRAC-1:0]) * P_W'(m_ff);
      neg2_ff <= neg_ff;
      w2_ff <= w1_ff;
      if (rsp_load) begin
         rsp_data_ff.filter_output <= ys_ff;
         rsp_data_ff.error_output <= es_ff;
      end
   end

   // Memory write ports: zero during the clearing sweep, the new sample on
   // accept, the adapted weight at the end of the update pipe.
   assign dl_we = (state_ff == S_CLEAR) || req_take;
   assign dl_waddr = (state_ff == S_CLEAR) ? k_ff : wi_ff;
   assign dl_wdata = (state_ff == S_CLEAR) ? '0 : req_data.reference_sample;
   assign wt_we = (state_ff == S_CLEAR) || (pv_ff && (state_ff == S_UPD));
   assign wt_waddr = (state_ff == S_CLEAR) ? k_ff : k3_ff;
   assign wt_wdata = (state_ff == S_CLEAR) ? '0 : nw_sat;

   nafir_store #(
      .TAPS(TAPS),
      .TW(TW)
   ) u_store (
      .clock(clock),
      .dl_we(dl_we),
      .dl_waddr(dl_waddr),
      .dl_wdata(dl_wdata),
      .dl_raddr(rd_ff),
      .dl_rdata(dl_rdata),
      .wt_we(wt_we),
      .wt_waddr(wt_waddr),
      .wt_wdata(wt_wdata),
      .wt_raddr(k_ff),
      .wt_rdata(wt_rdata)
   );

   nafir_div #(
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .step(step_ff),
      .den(den),
      .status(div_st),
      .quot(div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTH
   a_take_starts_sum: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_SUM) else $error("accepted word did not start sum");
   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_POST)) else $error("response outside post");
   a_weight_write_window: assert property (@(posedge clock) disable iff (reset)
      wt_we |-> (state_ff == S_UPD || state_ff == S_CLEAR)) else $error("stray weight write");
   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.busy |-> state_ff == S_DIV) else $error("divider busy outside divide");
`endif

endmodule
